### sv/imh_pkg.sv
// ============================================================================
// imh_pkg
// Shared types and constants of the indexed min-heap: field widths, opcodes,
// status codes and the control bundle that drives the row of level cells.
// ============================================================================
package imh_pkg;

  localparam int OPCODE_BITS = 3;
  localparam int HANDLE_BITS = 11;
  localparam int VALUE_W     = 32;
  localparam int COUNT_BITS  = 11;
  localparam int STATUS_BITS = 3;

  // level number and in-level row/offset as carried to the cells
  localparam int LVL_BITS = 5;
  localparam int ROW_BITS = 16;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT     = 3'd0,
    OP_PEEK       = 3'd1,
    OP_DEL_MIN    = 3'd2,
    OP_DEL_HANDLE = 3'd3,
    OP_CHANGE     = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_DEAD      = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

  // one read and one write request per cycle, each aimed at one level
  typedef struct packed {
    logic                rd_en;
    logic [LVL_BITS-1:0] rd_lvl;
    logic [ROW_BITS-1:0] rd_row;
    logic                wr_en;
    logic [LVL_BITS-1:0] wr_lvl;
    logic [ROW_BITS-1:0] wr_off;
  } cell_ctl_t;

endpackage

### sv/imh_in_if.sv
// ============================================================================
// imh_in_if
// Command channel of the indexed min-heap: valid/ready with opcode, handle
// and value.
// ============================================================================
interface imh_in_if import imh_pkg::*; ();

  logic                          valid;
  logic                          ready;
  logic        [OPCODE_BITS-1:0] opcode;
  logic        [HANDLE_BITS-1:0] handle;
  logic signed [VALUE_W-1:0]     value;

  modport source (output valid, output opcode, output handle, output value, input ready);
  modport sink   (input valid, input opcode, input handle, input value, output ready);

endinterface

### sv/imh_out_if.sv
// ============================================================================
// imh_out_if
// Result channel of the indexed min-heap: valid/ready with minimum, handle,
// count and status.
// ============================================================================
interface imh_out_if import imh_pkg::*; ();

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_W-1:0]     min_value;
  logic        [HANDLE_BITS-1:0] assigned_handle;
  logic        [COUNT_BITS-1:0]  entry_count;
  logic        [STATUS_BITS-1:0] status;

  modport source (output valid, output min_value, output assigned_handle,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input min_value, input assigned_handle,
                  input entry_count, input status, output ready);

endinterface

### sv/indexed_min_heap.sv
// ============================================================================
// indexed_min_heap
// Indexed binary min-heap of signed values with handle-based delete/change.
// ============================================================================
// Usage:
//  - in_if carries one command per transaction: insert, peek minimum, delete
//    minimum, delete by handle, change value by handle. Handles are issued
//    1, 2, 3... on successful inserts and never reused.
//  - out_if returns exactly one result per command: current minimum (0 when
//    empty), issued handle (0 unless an insert succeeded), entry count and
//    status. Error cases (empty, full, dead handle, handles exhausted) leave
//    the heap untouched.
//  - One command at a time. Peek and error cases go straight from decode to
//    finish; a sift visits up to LEVELS tree levels (LEVELS =
//    clog2(CAPACITY+1), 11 by default). Each tree level visited takes a
//    registered read from that level's cell, then a compare and one
//    write-back. in_if.ready returns in the same cycle that the result
//    appears in the output register.
//  - The result sits in an output register; if out_if.ready is low the block
//    holds the finished result and waits before finishing the next command.
//  - Reset clears the count, the handle counter and the output valid. The
//    heap storage needs no clearing: handles above the issue counter read as
//    dead, and removed handles get their position zeroed.
// ============================================================================
module indexed_min_heap import imh_pkg::*; #(
  parameter int CAPACITY     = 1024,
  parameter int HANDLE_LIMIT = 1024,
  parameter int VALUE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  imh_in_if.sink      in_if,
  imh_out_if.source   out_if
);

  localparam int SW     = $clog2(CAPACITY + 1);     // slot / count width
  localparam int HW     = $clog2(HANDLE_LIMIT + 1); // handle width
  localparam int VW     = VALUE_BITS;
  localparam int LEVELS = SW;                        // tree depth
  localparam int LW     = $clog2(LEVELS);
  localparam int EW     = VW + HW;
  localparam int PW     = 2 * EW;
  localparam int HCW    = (HW > HANDLE_BITS) ? HW : HANDLE_BITS;
  localparam logic [VW-1:0] KEY_FLIP = {1'b1, {(VW-1){1'b0}}};

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_DN_RD  = 8'b0000_0100,
    S_DN_CMP = 8'b0000_1000,
    S_UP_RD  = 8'b0001_0000,
    S_UP_CMP = 8'b0010_0000,
    S_PLACE  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  // index of the highest set bit = tree level of a slot number
  function automatic logic [LW-1:0] lvl_of(input logic [SW-1:0] x);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < SW; i++) begin
      if (x[i]) r = LW'(i);
    end
    return r;
  endfunction

  // control state
  state_t              state_r,   state_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [SW-1:0]       n_r,       n_nxt;       // live entries
  logic [HW-1:0]       next_r,    next_nxt;    // handles issued

  // per-command working registers
  logic [OPCODE_BITS-1:0] op_r,   op_nxt;
  logic [HANDLE_BITS-1:0] h_r,    h_nxt;
  logic [VW-1:0]          key_r,  key_nxt;
  logic [SW-1:0]          hole_r, hole_nxt;    // slot being settled
  logic [LW-1:0]          lvl_r,  lvl_nxt;     // its tree level
  logic [VW-1:0]          mkey_r, mkey_nxt;    // entry being moved
  logic [HW-1:0]          mhdl_r, mhdl_nxt;
  logic                   moved_r, moved_nxt;
  logic                   half_r, half_nxt;    // which half of a read pair
  status_t                stat_r, stat_nxt;
  logic [HW-1:0]          asgn_r, asgn_nxt;

  // cached copy of slot 1
  logic [VW-1:0]          root_key_r, root_key_nxt;
  logic [HW-1:0]          root_hdl_r, root_hdl_nxt;

  // result register
  logic [VALUE_W-1:0]     out_min_r,  out_min_nxt;
  logic [HANDLE_BITS-1:0] out_hdl_r,  out_hdl_nxt;
  logic [COUNT_BITS-1:0]  out_cnt_r,  out_cnt_nxt;
  logic [STATUS_BITS-1:0] out_stat_r, out_stat_nxt;

  // cell chain
  cell_ctl_t     ctl;
  logic [VW-1:0] wr_key;
  logic [HW-1:0] wr_hdl;
  logic [PW-1:0] chain [LEVELS+1];
  logic [PW-1:0] rd_pair;
  logic [VW-1:0] ev_key, od_key;
  logic [HW-1:0] ev_hdl, od_hdl;

  // position map
  logic          pos_we;
  logic [HW-1:0] pos_waddr;
  logic [SW-1:0] pos_wdata;
  logic [SW-1:0] pos_q;

  // decode helpers
  logic [SW-1:0] n_off, hole_off, rem_p;
  logic [HW-1:0] rem_dead;
  logic          h_ok, live;
  logic [VW-1:0] last_key, par_key, cmp_key;
  logic [HW-1:0] last_hdl, par_hdl;
  logic          take_l, take_r, r_ok;
  logic [VW-1:0] min_raw;

  assign chain[0] = '0;

  for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
    imh_level_cell #(.LVL(g), .VW(VW), .HW(HW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_key  (wr_key),
      .wr_hdl  (wr_hdl),
      .up_pair (chain[g]),
      .dn_pair (chain[g+1])
    );
  end

  assign rd_pair = chain[LEVELS];
  assign ev_key  = rd_pair[PW-1 -: VW];
  assign ev_hdl  = rd_pair[PW-VW-1 -: HW];
  assign od_key  = rd_pair[EW-1 -: VW];
  assign od_hdl  = rd_pair[HW-1:0];

  // handle -> slot; read address follows the command port so the entry is
  // ready in the decode cycle
  imh_ram #(.WIDTH(SW), .DEPTH(HANDLE_LIMIT + 1)) u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (HW'(in_if.handle)),
    .rdata (pos_q)
  );

  assign in_if.ready = (state_r == S_IDLE);

  assign n_off    = n_r ^ (SW'(1) << lvl_of(n_r));
  assign hole_off = hole_r ^ (SW'(1) << lvl_r);

  assign last_key = half_r ? od_key : ev_key;
  assign last_hdl = half_r ? od_hdl : ev_hdl;
  assign par_key  = half_r ? od_key : ev_key;
  assign par_hdl  = half_r ? od_hdl : ev_hdl;

  // a handle is live only if issued and still holding a slot
  assign h_ok = (h_r != '0) && (HCW'(h_r) <= HCW'(next_r));
  assign live = h_ok && (pos_q != '0) && (pos_q <= n_r);

  assign rem_p    = (op_r == OP_DEL_MIN) ? SW'(1) : pos_q;
  assign rem_dead = (op_r == OP_DEL_MIN) ? root_hdl_r : HW'(h_r);

  // sift-down child choice; ties keep the left child / the parent
  assign r_ok    = hole_r <= ((n_r - SW'(1)) >> 1);
  assign take_l  = ev_key < mkey_r;
  assign cmp_key = take_l ? ev_key : mkey_r;
  assign take_r  = r_ok && (od_key < cmp_key);

  assign min_raw = root_key_r ^ KEY_FLIP;

  always_comb begin
    state_nxt    = state_r;
    out_vld_nxt  = out_vld_r;
    n_nxt        = n_r;
    next_nxt     = next_r;
    op_nxt       = op_r;
    h_nxt        = h_r;
    key_nxt      = key_r;
    hole_nxt     = hole_r;
    lvl_nxt      = lvl_r;
    mkey_nxt     = mkey_r;
    mhdl_nxt     = mhdl_r;
    moved_nxt    = moved_r;
    half_nxt     = half_r;
    stat_nxt     = stat_r;
    asgn_nxt     = asgn_r;
    out_min_nxt  = out_min_r;
    out_hdl_nxt  = out_hdl_r;
    out_cnt_nxt  = out_cnt_r;
    out_stat_nxt = out_stat_r;
    ctl          = '0;
    wr_key       = mkey_r;
    wr_hdl       = mhdl_r;
    pos_we       = 1'b0;
    pos_waddr    = mhdl_r;
    pos_wdata    = hole_r;

    if (out_vld_r && out_if.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          op_nxt      = in_if.opcode;
          h_nxt       = in_if.handle;
          key_nxt     = VW'(in_if.value) ^ KEY_FLIP;
          stat_nxt    = ST_OK;
          asgn_nxt    = '0;
          // fetch the last slot in case this is a removal
          ctl.rd_en   = 1'b1;
          ctl.rd_lvl  = LVL_BITS'(lvl_of(n_r));
          ctl.rd_row  = ROW_BITS'(n_off >> 1);
          half_nxt    = n_off[0];
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        moved_nxt = 1'b0;
        state_nxt = S_FINISH;
        case (op_r)
          OP_INSERT: begin
            if (n_r == SW'(CAPACITY)) begin
              stat_nxt = ST_FULL;
            end else if (next_r == HW'(HANDLE_LIMIT)) begin
              stat_nxt = ST_EXHAUSTED;
            end else begin
              next_nxt  = next_r + HW'(1);
              n_nxt     = n_r + SW'(1);
              asgn_nxt  = next_r + HW'(1);
              mkey_nxt  = key_r;
              mhdl_nxt  = next_r + HW'(1);
              hole_nxt  = n_r + SW'(1);
              lvl_nxt   = lvl_of(n_r + SW'(1));
              state_nxt = S_UP_RD;
            end
          end
          OP_PEEK: begin
            if (n_r == '0) stat_nxt = ST_EMPTY;
          end
          OP_DEL_MIN, OP_DEL_HANDLE: begin
            if ((op_r == OP_DEL_MIN) && (n_r == '0)) begin
              stat_nxt = ST_EMPTY;
            end else if ((op_r == OP_DEL_HANDLE) && !live) begin
              stat_nxt = ST_DEAD;
            end else begin
              // removed handle is dead for good
              pos_we    = 1'b1;
              pos_waddr = rem_dead;
              pos_wdata = '0;
              mkey_nxt  = last_key;
              mhdl_nxt  = last_hdl;
              n_nxt     = n_r - SW'(1);
              hole_nxt  = rem_p;
              lvl_nxt   = lvl_of(rem_p);
              // removing the last slot needs no sift
              if (rem_p != n_r) state_nxt = S_DN_RD;
            end
          end
          OP_CHANGE: begin
            if (!live) begin
              stat_nxt = ST_DEAD;
            end else begin
              mkey_nxt  = key_r;
              mhdl_nxt  = HW'(h_r);
              hole_nxt  = pos_q;
              lvl_nxt   = lvl_of(pos_q);
              state_nxt = S_DN_RD;
            end
          end
          default: begin
          end
        endcase
      end

      S_DN_RD: begin
        if (hole_r <= (n_r >> 1)) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_lvl = LVL_BITS'(lvl_r) + LVL_BITS'(1);
          ctl.rd_row = ROW_BITS'(hole_off);
          state_nxt  = S_DN_CMP;
        end else begin
          state_nxt = moved_r ? S_PLACE : S_UP_RD;
        end
      end

      S_DN_CMP: begin
        if (take_l || take_r) begin
          // pull the smaller child up into the hole
          ctl.wr_en  = 1'b1;
          ctl.wr_lvl = LVL_BITS'(lvl_r);
          ctl.wr_off = ROW_BITS'(hole_off);
          wr_key     = take_r ? od_key : ev_key;
          wr_hdl     = take_r ? od_hdl : ev_hdl;
          pos_we     = 1'b1;
          pos_waddr  = take_r ? od_hdl : ev_hdl;
          pos_wdata  = hole_r;
          hole_nxt   = {hole_r[SW-2:0], take_r};
          lvl_nxt    = lvl_r + LW'(1);
          moved_nxt  = 1'b1;
          state_nxt  = S_DN_RD;
        end else begin
          state_nxt = moved_r ? S_PLACE : S_UP_RD;
        end
      end

      S_UP_RD: begin
        if (hole_r != SW'(1)) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_lvl = LVL_BITS'(lvl_r - LW'(1));
          ctl.rd_row = ROW_BITS'(hole_off >> 2);
          half_nxt   = hole_off[1];
          state_nxt  = S_UP_CMP;
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_UP_CMP: begin
        if (par_key > mkey_r) begin
          // push the parent down into the hole
          ctl.wr_en  = 1'b1;
          ctl.wr_lvl = LVL_BITS'(lvl_r);
          ctl.wr_off = ROW_BITS'(hole_off);
          wr_key     = par_key;
          wr_hdl     = par_hdl;
          pos_we     = 1'b1;
          pos_waddr  = par_hdl;
          pos_wdata  = hole_r;
          hole_nxt   = hole_r >> 1;
          lvl_nxt    = lvl_r - LW'(1);
          state_nxt  = S_UP_RD;
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_lvl = LVL_BITS'(lvl_r);
        ctl.wr_off = ROW_BITS'(hole_off);
        pos_we     = 1'b1;
        state_nxt  = S_FINISH;
      end

      S_FINISH: begin
        if (!out_vld_r || out_if.ready) begin
          out_vld_nxt  = 1'b1;
          out_min_nxt  = (n_r == '0) ? '0 : VALUE_W'(min_raw);
          out_hdl_nxt  = HANDLE_BITS'(asgn_r);
          out_cnt_nxt  = COUNT_BITS'(n_r);
          out_stat_nxt = stat_r;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // keep the slot-1 copy in step with every write to the root
    root_key_nxt = root_key_r;
    root_hdl_nxt = root_hdl_r;
    if (ctl.wr_en && (ctl.wr_lvl == '0)) begin
      root_key_nxt = wr_key;
      root_hdl_nxt = wr_hdl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      n_r       <= '0;
      next_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      n_r       <= n_nxt;
      next_r    <= next_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    h_r        <= h_nxt;
    key_r      <= key_nxt;
    hole_r     <= hole_nxt;
    lvl_r      <= lvl_nxt;
    mkey_r     <= mkey_nxt;
    mhdl_r     <= mhdl_nxt;
    moved_r    <= moved_nxt;
    half_r     <= half_nxt;
    stat_r     <= stat_nxt;
    asgn_r     <= asgn_nxt;
    root_key_r <= root_key_nxt;
    root_hdl_r <= root_hdl_nxt;
    out_min_r  <= out_min_nxt;
    out_hdl_r  <= out_hdl_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_if.valid           = out_vld_r;
  assign out_if.min_value       = out_min_r;
  assign out_if.assigned_handle = out_hdl_r;
  assign out_if.entry_count     = out_cnt_r;
  assign out_if.status          = out_stat_r;

endmodule

### sv/imh_ram.sv
// ============================================================================
// imh_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/imh_level_cell.sv
// ============================================================================
// imh_level_cell
// One level of the heap tree. Slots are kept as sibling pairs (even/odd
// offset) so a parent's two children come back in one read. Read data is
// passed along the chain of cells; the cell that was addressed inserts its
// own pair.
// ============================================================================
module imh_level_cell import imh_pkg::*; #(
  parameter int LVL = 0,
  parameter int VW  = 32,
  parameter int HW  = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_ctl_t               ctl,
  input  logic [VW-1:0]           wr_key,
  input  logic [HW-1:0]           wr_hdl,
  input  logic [2*(VW+HW)-1:0]    up_pair,
  output logic [2*(VW+HW)-1:0]    dn_pair
);

  localparam int ROWS = (LVL >= 2) ? (1 << (LVL - 1)) : 2;
  localparam int RAW  = $clog2(ROWS);
  localparam int EW   = VW + HW;

  logic          rd_hit;
  logic          wr_hit;
  logic          rd_hit_r;
  logic [EW-1:0] even_q;
  logic [EW-1:0] odd_q;

  assign rd_hit = ctl.rd_en && (ctl.rd_lvl == LVL_BITS'(LVL));
  assign wr_hit = ctl.wr_en && (ctl.wr_lvl == LVL_BITS'(LVL));

  imh_ram #(.WIDTH(EW), .DEPTH(ROWS)) u_even (
    .clk   (clk),
    .we    (wr_hit && !ctl.wr_off[0]),
    .waddr (ctl.wr_off[RAW:1]),
    .wdata ({wr_key, wr_hdl}),
    .raddr (ctl.rd_row[RAW-1:0]),
    .rdata (even_q)
  );

  imh_ram #(.WIDTH(EW), .DEPTH(ROWS)) u_odd (
    .clk   (clk),
    .we    (wr_hit && ctl.wr_off[0]),
    .waddr (ctl.wr_off[RAW:1]),
    .wdata ({wr_key, wr_hdl}),
    .raddr (ctl.rd_row[RAW-1:0]),
    .rdata (odd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_hit_r <= 1'b0;
    end else begin
      rd_hit_r <= rd_hit;
    end
  end

  assign dn_pair = rd_hit_r ? {even_q, odd_q} : up_pair;

endmodule

### sv/imh_checker.sv
// ============================================================================
// imh_checker
// Port-level checks of the indexed min-heap, bound to the top level.
// ============================================================================
module imh_checker import imh_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  imh_in_if.sink    in_m,
  imh_out_if.source out_m
);

  // no result survives reset
  a_rst_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_m.valid)
    else $error("result valid right after reset");

  // one command in flight: ready drops after each accepted transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_m.valid && in_m.ready) |=> !in_m.ready)
    else $error("command accepted while another is in flight");

  // a handle is only issued by a successful insert
  a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_m.valid && (out_m.assigned_handle != '0)) |-> (out_m.status == ST_OK))
    else $error("handle issued with error status");

  // an empty heap reports a zero minimum
  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_m.valid && (out_m.entry_count == '0)) |-> (out_m.min_value == '0))
    else $error("nonzero minimum from an empty heap");

endmodule

bind indexed_min_heap imh_checker u_imh_checker (
  .clk   (clk),
  .rst_n (rst_n),
  .in_m  (in_if),
  .out_m (out_if)
);
